// File: src/scp_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and arithmetic helpers for the spline control point core.
// No dependencies; every other file of the block uses this package.
package scp_pkg;

    localparam int COORD_W = 16;              // Q12.4 coordinate
    localparam int T_W     = 16;              // Q1.15 tension / factor
    localparam int DIFF_W  = COORD_W + 1;     // exact coordinate difference
    localparam int SQ_W    = 2 * DIFF_W;      // sum of two squares
    localparam int ROOT_W  = DIFF_W;          // integer square root
    localparam int SUM_W   = ROOT_W + 1;      // d01 + d12
    localparam int NUM_W   = T_W + ROOT_W + 1; // t*d + s/2
    localparam int PROD_W  = 2 * DIFF_W;      // factor times chord
    localparam int OFF_W   = PROD_W + 1 - 15; // rounded offset
    localparam int WIDE_W  = OFF_W + 1;       // mid +/- offset

    localparam logic [T_W-1:0] TENSION_RESET = 16'd16384;
    localparam logic [PROD_W:0] HALF_Q15     = (PROD_W+1)'(16384);

    typedef struct packed {
        logic signed [DIFF_W-1:0]  cx;
        logic signed [DIFF_W-1:0]  cy;
        logic signed [COORD_W-1:0] mx;
        logic signed [COORD_W-1:0] my;
    } t_side;

    typedef struct packed {
        logic [SQ_W-1:0] v;
        logic [SQ_W-1:0] res;
    } t_sqrt;

    typedef struct packed {
        logic              clip;
        logic [COORD_W-1:0] val;
    } t_sat;

    // one digit of the bit-pair square root
    function automatic t_sqrt sqrt_step(input t_sqrt a, input logic [SQ_W-1:0] bitv);
        t_sqrt           r;
        logic [SQ_W-1:0] trial;
        trial = a.res + bitv;
        if (a.v >= trial) begin
            r.v   = a.v - trial;
            r.res = (a.res >> 1) + bitv;
        end else begin
            r.v   = a.v;
            r.res = a.res >> 1;
        end
        return r;
    endfunction

    // round an offset product to nearest, halves toward plus infinity
    function automatic logic signed [OFF_W-1:0] round_q15(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W:0] s;
        s = {p[PROD_W-1], p} + $signed(HALF_Q15);
        return s[PROD_W:15];
    endfunction

    function automatic t_sat sat_coord(input logic signed [WIDE_W-1:0] v);
        t_sat r;
        if (v > $signed(WIDE_W'(32767))) begin
            r.clip = 1'b1;
            r.val  = 16'h7FFF;
        end else if (v < -$signed(WIDE_W'(32768))) begin
            r.clip = 1'b1;
            r.val  = 16'h8000;
        end else begin
            r.clip = 1'b0;
            r.val  = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: src/scp_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the spline control point core: point triples in,
// control points out, tension writes. Depends on scp_pkg for widths.
interface scp_pt_if;
    logic                               valid;
    logic                               ready;
    logic signed [scp_pkg::COORD_W-1:0] prev_x;
    logic signed [scp_pkg::COORD_W-1:0] prev_y;
    logic signed [scp_pkg::COORD_W-1:0] mid_x;
    logic signed [scp_pkg::COORD_W-1:0] mid_y;
    logic signed [scp_pkg::COORD_W-1:0] next_x;
    logic signed [scp_pkg::COORD_W-1:0] next_y;
    modport source (output valid, prev_x, prev_y, mid_x, mid_y, next_x, next_y, input ready);
    modport sink   (input valid, prev_x, prev_y, mid_x, mid_y, next_x, next_y, output ready);
endinterface

interface scp_cp_if;
    logic                               valid;
    logic                               ready;
    logic signed [scp_pkg::COORD_W-1:0] before_x;
    logic signed [scp_pkg::COORD_W-1:0] before_y;
    logic signed [scp_pkg::COORD_W-1:0] after_x;
    logic signed [scp_pkg::COORD_W-1:0] after_y;
    logic                               clipped;
    modport source (output valid, before_x, before_y, after_x, after_y, clipped, input ready);
    modport sink   (input valid, before_x, before_y, after_x, after_y, clipped, output ready);
endinterface

interface scp_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [scp_pkg::T_W-1:0]        tension;
    modport source (output valid, tension, input ready);
    modport sink   (input valid, tension, output ready);
endinterface

// File: src/scp_sqrt_cell.sv
`timescale 1ns / 1ps
// One root digit for both distances; cells are chained, one per result bit.
// Depends on scp_pkg.
module scp_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  scp_pkg::t_sqrt        i_a,
    input  scp_pkg::t_sqrt        i_b,
    output scp_pkg::t_sqrt        o_a,
    output scp_pkg::t_sqrt        o_b
);
    localparam logic [scp_pkg::SQ_W-1:0] BITV =
        scp_pkg::SQ_W'(1) << (2 * (scp_pkg::ROOT_W - 1 - STEP));

    scp_pkg::t_sqrt r_a, r_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= scp_pkg::sqrt_step(i_a, BITV);
            r_b <= scp_pkg::sqrt_step(i_b, BITV);
        end
    end

    assign o_a = r_a;
    assign o_b = r_b;
endmodule

// File: src/scp_div_cell.sv
`timescale 1ns / 1ps
// One quotient bit of both tension splits; restoring division, one cell per bit.
// Depends on scp_pkg.
module scp_div_cell #(
    parameter int STEP = 0
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [scp_pkg::SUM_W-1:0]   i_den,
    input  logic [scp_pkg::NUM_W-1:0]   i_rem_a,
    input  logic [scp_pkg::NUM_W-1:0]   i_rem_b,
    input  logic [scp_pkg::T_W-1:0]     i_q_a,
    input  logic [scp_pkg::T_W-1:0]     i_q_b,
    output logic [scp_pkg::SUM_W-1:0]   o_den,
    output logic [scp_pkg::NUM_W-1:0]   o_rem_a,
    output logic [scp_pkg::NUM_W-1:0]   o_rem_b,
    output logic [scp_pkg::T_W-1:0]     o_q_a,
    output logic [scp_pkg::T_W-1:0]     o_q_b
);
    localparam int SH = scp_pkg::T_W - 1 - STEP;

    logic [scp_pkg::NUM_W-1:0] w_dsh;
    logic                      w_ge_a, w_ge_b;
    logic [scp_pkg::SUM_W-1:0] r_den;
    logic [scp_pkg::NUM_W-1:0] r_rem_a, r_rem_b;
    logic [scp_pkg::T_W-1:0]   r_q_a, r_q_b;

    assign w_dsh  = scp_pkg::NUM_W'(i_den) << SH;
    assign w_ge_a = i_rem_a >= w_dsh;
    assign w_ge_b = i_rem_b >= w_dsh;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den   <= i_den;
            r_rem_a <= w_ge_a ? i_rem_a - w_dsh : i_rem_a;
            r_rem_b <= w_ge_b ? i_rem_b - w_dsh : i_rem_b;
            r_q_a   <= {i_q_a[scp_pkg::T_W-2:0], w_ge_a};
            r_q_b   <= {i_q_b[scp_pkg::T_W-2:0], w_ge_b};
        end
    end

    assign o_den   = r_den;
    assign o_rem_a = r_rem_a;
    assign o_rem_b = r_rem_b;
    assign o_q_a   = r_q_a;
    assign o_q_b   = r_q_b;
endmodule

// File: src/spline_control_points_core.sv
`timescale 1ns / 1ps
// Top level of the spline control point core: front stages, root and divider
// cell chains, offset and saturation stages. Depends on scp_pkg, scp_if, cells.
//
// Usage:
//   i_pt carries one beat per point triple (prev, mid, next, signed Q12.4).
//   o_cp returns one beat per triple: the incoming (before) and outgoing (after)
//   Bezier control points around mid, rounded, saturated, with a clipped flag.
//   i_cfg writes the tension (Q1.15, 32768 = 1.0); it is always ready. The user
//   writes it only while no triple is in flight; the block does not enforce this.
// Pipeline: an accepted input beat passes through three front stages
//   (differences, squares, sums), 17 square root cells, one numerator stage,
//   16 divider cells, one product stage and one output stage to the output beat.
// Throughput: one triple per cycle while no stall holds the pipe. The whole pipe
//   advances together; the rate is set by the output register, which frees when taken.
// Stall: while the output beat waits and o_cp.ready is low, every stage holds
//   and i_pt.ready drops; no beat is lost or repeated.
// Reset: i_rst_n low clears all stage valid bits and sets tension to 0.5.
// Coincident points: if both distances are zero, both factors are forced to
//   zero so both control points equal mid with clipped low.
module spline_control_points_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    scp_cfg_if.sink         i_cfg,
    scp_pt_if.sink          i_pt,
    scp_cp_if.source        o_cp
);
    localparam int NSQ   = scp_pkg::ROOT_W;        // root cells
    localparam int NDV   = scp_pkg::T_W;           // divider cells
    localparam int V_NUM = 3 + NSQ;                // valid index of numerator stage
    localparam int V_DIV = V_NUM + NDV;            // valid index of divider output
    localparam int V_LEN = V_DIV + 3;              // + product + output stage

    logic                        w_en;
    logic [V_LEN-1:0]            r_vld;
    logic [scp_pkg::T_W-1:0]     r_tension;

    // front stage registers
    logic signed [scp_pkg::DIFF_W-1:0] r_dx01, r_dy01, r_dx12, r_dy12;
    logic [scp_pkg::SQ_W-1:0]          r_qx01, r_qy01, r_qx12, r_qy12;
    scp_pkg::t_sqrt                    r_sa0, r_sb0;
    scp_pkg::t_sqrt                    w_sa [0:NSQ];
    scp_pkg::t_sqrt                    w_sb [0:NSQ];
    scp_pkg::t_side                    r_side [0:V_DIV];

    // divider chain
    logic [scp_pkg::SUM_W-1:0]   w_den   [0:NDV];
    logic [scp_pkg::NUM_W-1:0]   w_rem_a [0:NDV];
    logic [scp_pkg::NUM_W-1:0]   w_rem_b [0:NDV];
    logic [scp_pkg::T_W-1:0]     w_q_a   [0:NDV];
    logic [scp_pkg::T_W-1:0]     w_q_b   [0:NDV];
    logic [NDV:0]                r_zero;

    // numerator stage
    logic [scp_pkg::ROOT_W-1:0]  w_d01, w_d12;
    logic [scp_pkg::SUM_W-1:0]   w_s;
    logic [scp_pkg::SUM_W-1:0]   r_s;
    logic [scp_pkg::NUM_W-1:0]   r_num_a, r_num_b;

    // product and output stages
    logic [scp_pkg::T_W-1:0]            w_fa, w_fb;
    logic signed [scp_pkg::PROD_W-1:0]  r_pax, r_pay, r_pbx, r_pby;
    logic signed [scp_pkg::COORD_W-1:0] r_mx, r_my;
    scp_pkg::t_sat                      w_bx, w_by, w_ax, w_ay;
    logic signed [scp_pkg::COORD_W-1:0] r_bx, r_by, r_ax, r_ay;
    logic                               r_clip;

    // advance the whole pipe unless the output beat is stuck
    assign w_en        = !r_vld[V_LEN-1] || o_cp.ready;
    assign i_pt.ready  = w_en;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tension <= scp_pkg::TENSION_RESET;
        end else if (i_cfg.valid) begin
            r_tension <= i_cfg.tension;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[V_LEN-2:0], i_pt.valid};
        end
    end

    // differences, squares, sums of squares
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dx01 <= scp_pkg::DIFF_W'(i_pt.mid_x) - scp_pkg::DIFF_W'(i_pt.prev_x);
            r_dy01 <= scp_pkg::DIFF_W'(i_pt.mid_y) - scp_pkg::DIFF_W'(i_pt.prev_y);
            r_dx12 <= scp_pkg::DIFF_W'(i_pt.next_x) - scp_pkg::DIFF_W'(i_pt.mid_x);
            r_dy12 <= scp_pkg::DIFF_W'(i_pt.next_y) - scp_pkg::DIFF_W'(i_pt.mid_y);
            r_side[0].cx <= scp_pkg::DIFF_W'(i_pt.next_x) - scp_pkg::DIFF_W'(i_pt.prev_x);
            r_side[0].cy <= scp_pkg::DIFF_W'(i_pt.next_y) - scp_pkg::DIFF_W'(i_pt.prev_y);
            r_side[0].mx <= i_pt.mid_x;
            r_side[0].my <= i_pt.mid_y;
            r_qx01 <= $unsigned(scp_pkg::SQ_W'(r_dx01) * scp_pkg::SQ_W'(r_dx01));
            r_qy01 <= $unsigned(scp_pkg::SQ_W'(r_dy01) * scp_pkg::SQ_W'(r_dy01));
            r_qx12 <= $unsigned(scp_pkg::SQ_W'(r_dx12) * scp_pkg::SQ_W'(r_dx12));
            r_qy12 <= $unsigned(scp_pkg::SQ_W'(r_dy12) * scp_pkg::SQ_W'(r_dy12));
            r_sa0.v   <= r_qx01 + r_qy01;
            r_sa0.res <= '0;
            r_sb0.v   <= r_qx12 + r_qy12;
            r_sb0.res <= '0;
            for (int k = 1; k <= V_DIV; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign w_sa[0] = r_sa0;
    assign w_sb[0] = r_sb0;

    // square root chain: one result bit per cell
    for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
        scp_sqrt_cell #(.STEP(g)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (w_sa[g]),
            .i_b   (w_sb[g]),
            .o_a   (w_sa[g+1]),
            .o_b   (w_sb[g+1])
        );
    end

    // numerators t*d + s/2 and the shared divisor
    assign w_d01 = w_sa[NSQ].res[scp_pkg::ROOT_W-1:0];
    assign w_d12 = w_sb[NSQ].res[scp_pkg::ROOT_W-1:0];
    assign w_s   = scp_pkg::SUM_W'(w_d01) + scp_pkg::SUM_W'(w_d12);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s       <= w_s;
            r_zero[0] <= (w_s == '0);
            r_num_a   <= scp_pkg::NUM_W'(r_tension * w_d01) + scp_pkg::NUM_W'(w_s >> 1);
            r_num_b   <= scp_pkg::NUM_W'(r_tension * w_d12) + scp_pkg::NUM_W'(w_s >> 1);
            for (int k = 1; k <= NDV; k++) begin
                r_zero[k] <= r_zero[k-1];
            end
        end
    end

    assign w_den[0]   = r_s;
    assign w_rem_a[0] = r_num_a;
    assign w_rem_b[0] = r_num_b;
    assign w_q_a[0]   = '0;
    assign w_q_b[0]   = '0;

    // divider chain: one quotient bit per cell
    for (genvar g = 0; g < NDV; g++) begin : g_div
        scp_div_cell #(.STEP(g)) u_cell (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_den   (w_den[g]),
            .i_rem_a (w_rem_a[g]),
            .i_rem_b (w_rem_b[g]),
            .i_q_a   (w_q_a[g]),
            .i_q_b   (w_q_b[g]),
            .o_den   (w_den[g+1]),
            .o_rem_a (w_rem_a[g+1]),
            .o_rem_b (w_rem_b[g+1]),
            .o_q_a   (w_q_a[g+1]),
            .o_q_b   (w_q_b[g+1])
        );
    end

    // drop the factors when all three points coincide
    assign w_fa = r_zero[NDV] ? '0 : w_q_a[NDV];
    assign w_fb = r_zero[NDV] ? '0 : w_q_b[NDV];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pax <= $signed({1'b0, w_fa}) * r_side[V_DIV].cx;
            r_pay <= $signed({1'b0, w_fa}) * r_side[V_DIV].cy;
            r_pbx <= $signed({1'b0, w_fb}) * r_side[V_DIV].cx;
            r_pby <= $signed({1'b0, w_fb}) * r_side[V_DIV].cy;
            r_mx  <= r_side[V_DIV].mx;
            r_my  <= r_side[V_DIV].my;
        end
    end

    // round offsets, move mid, saturate
    assign w_bx = scp_pkg::sat_coord(scp_pkg::WIDE_W'(r_mx) -
                                     scp_pkg::WIDE_W'(scp_pkg::round_q15(r_pax)));
    assign w_by = scp_pkg::sat_coord(scp_pkg::WIDE_W'(r_my) -
                                     scp_pkg::WIDE_W'(scp_pkg::round_q15(r_pay)));
    assign w_ax = scp_pkg::sat_coord(scp_pkg::WIDE_W'(r_mx) +
                                     scp_pkg::WIDE_W'(scp_pkg::round_q15(r_pbx)));
    assign w_ay = scp_pkg::sat_coord(scp_pkg::WIDE_W'(r_my) +
                                     scp_pkg::WIDE_W'(scp_pkg::round_q15(r_pby)));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_bx   <= w_bx.val;
            r_by   <= w_by.val;
            r_ax   <= w_ax.val;
            r_ay   <= w_ay.val;
            r_clip <= w_bx.clip | w_by.clip | w_ax.clip | w_ay.clip;
        end
    end

    assign o_cp.valid    = r_vld[V_LEN-1];
    assign o_cp.before_x = r_bx;
    assign o_cp.before_y = r_by;
    assign o_cp.after_x  = r_ax;
    assign o_cp.after_y  = r_ay;
    assign o_cp.clipped  = r_clip;
endmodule

// File: sim/spline_control_points_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for spline_control_points_core: drives point triples
// and tension writes, predicts each control-point beat. Depends on scp_pkg, scp_if.
module spline_control_points_core_tb;

    localparam int LATENCY   = 39;
    localparam int WDOG_MAX  = 20000;

    typedef struct packed {
        logic signed [15:0] px, py, mx, my, nx, ny;
    } t_triple;

    typedef struct packed {
        logic signed [15:0] bx, by, ax, ay;
        logic               clip;
    } t_ctrl;

    logic i_clk;
    logic i_rst_n;

    scp_cfg_if cfg_ch();
    scp_pt_if  pt_ch();
    scp_cp_if  cp_ch();

    spline_control_points_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch.sink),
        .i_pt    (pt_ch.sink),
        .o_cp    (cp_ch.source)
    );

    // predictor copy of the tension register
    logic [15:0] tension_q15;
    t_ctrl       ctrl_pending[$];
    int          errors;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_off;
    int          hold_cycles;
    int          quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint root_floor(longint v);
        longint r;
        longint b;
        r = 0;
        b = 64'd1 << 40;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint round_off(longint v);
        if (v >= 0) return v / 32768;
        return -((-v + 32767) / 32768);
    endfunction

    function automatic logic signed [15:0] clamp(longint v, inout logic c);
        if (v > 32767) begin
            c = 1'b1;
            return 16'sh7FFF;
        end
        if (v < -32768) begin
            c = 1'b1;
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    function automatic t_ctrl predict_ctrl(t_triple p);
        longint dx0, dy0, dx1, dy1, d01, d12, s, fa, fb, cx, cy;
        t_ctrl  r;
        logic   c;
        dx0 = p.mx - p.px;
        dy0 = p.my - p.py;
        dx1 = p.nx - p.mx;
        dy1 = p.ny - p.my;
        d01 = root_floor(dx0 * dx0 + dy0 * dy0);
        d12 = root_floor(dx1 * dx1 + dy1 * dy1);
        s   = d01 + d12;
        fa  = 0;
        fb  = 0;
        if (s != 0) begin
            fa = (longint'(tension_q15) * d01 + s / 2) / s;
            fb = (longint'(tension_q15) * d12 + s / 2) / s;
        end
        cx = p.nx - p.px;
        cy = p.ny - p.py;
        c  = 1'b0;
        r.bx = clamp(p.mx - round_off(fa * cx + 16384), c);
        r.by = clamp(p.my - round_off(fa * cy + 16384), c);
        r.ax = clamp(p.mx + round_off(fb * cx + 16384), c);
        r.ay = clamp(p.my + round_off(fb * cy + 16384), c);
        r.clip = c;
        return r;
    endfunction

    // receiver: random stall, plus a long hold-off when requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cp_ch.ready <= 1'b0;
            hold_cycles <= 0;
        end else if (hold_off) begin
            cp_ch.ready <= 1'b0;
            hold_cycles <= hold_cycles + 1;
        end else begin
            cp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // check each accepted result beat against the oldest prediction
    always @(posedge i_clk) begin
        t_ctrl exp_c;
        if (i_rst_n && cp_ch.valid && cp_ch.ready) begin
            if (ctrl_pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat bx=%0d by=%0d ax=%0d ay=%0d", $time,
                         cp_ch.before_x, cp_ch.before_y, cp_ch.after_x, cp_ch.after_y);
            end else begin
                exp_c = ctrl_pending.pop_front();
                if (cp_ch.before_x !== exp_c.bx) begin
                    errors++;
                    $display("%0t: before_x exp %0d got %0d", $time, exp_c.bx, cp_ch.before_x);
                end
                if (cp_ch.before_y !== exp_c.by) begin
                    errors++;
                    $display("%0t: before_y exp %0d got %0d", $time, exp_c.by, cp_ch.before_y);
                end
                if (cp_ch.after_x !== exp_c.ax) begin
                    errors++;
                    $display("%0t: after_x exp %0d got %0d", $time, exp_c.ax, cp_ch.after_x);
                end
                if (cp_ch.after_y !== exp_c.ay) begin
                    errors++;
                    $display("%0t: after_y exp %0d got %0d", $time, exp_c.ay, cp_ch.after_y);
                end
                if (cp_ch.clipped !== exp_c.clip) begin
                    errors++;
                    $display("%0t: clipped exp %0b got %0b", $time, exp_c.clip, cp_ch.clipped);
                end
            end
        end
    end

    // watchdog: count cycles with no beat on any channel
    always @(posedge i_clk) begin
        if ((pt_ch.valid && pt_ch.ready) || (cp_ch.valid && cp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || hold_off)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // send one triple, with random idle cycles ahead of it; valid stays up
    // after the beat so the next triple can follow in the very next cycle
    task automatic send_triple(t_triple p);
        while ($urandom_range(99) < send_idle_pct) begin
            pt_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pt_ch.valid  <= 1'b1;
        pt_ch.prev_x <= p.px;
        pt_ch.prev_y <= p.py;
        pt_ch.mid_x  <= p.mx;
        pt_ch.mid_y  <= p.my;
        pt_ch.next_x <= p.nx;
        pt_ch.next_y <= p.ny;
        do @(posedge i_clk); while (!pt_ch.ready);
        ctrl_pending.push_back(predict_ctrl(p));
    endtask

    task automatic drain();
        pt_ch.valid <= 1'b0;
        while (ctrl_pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic write_tension(logic [15:0] t);
        drain();
        cfg_ch.valid   <= 1'b1;
        cfg_ch.tension <= t;
        do @(posedge i_clk); while (!cfg_ch.ready);
        tension_q15 = t;
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_triple rand_triple();
        t_triple p;
        int      span;
        // mostly nearby points with random spacing, some full-range noise
        if ($urandom_range(3) == 0) begin
            p = {$urandom, $urandom, $urandom};
        end else begin
            span = 1 << $urandom_range(14, 2);
            p.mx = 16'($urandom);
            p.px = 16'(p.mx + $signed($urandom_range(2 * span) - span));
            p.my = 16'($urandom);
            p.py = 16'(p.my + $signed($urandom_range(2 * span) - span));
            p.nx = 16'(p.mx + $signed($urandom_range(2 * span) - span));
            p.ny = 16'(p.my + $signed($urandom_range(2 * span) - span));
        end
        return p;
    endfunction

    task automatic test_directed();
        t_triple p;
        p = '{16'sd100, 16'sd100, 16'sd100, 16'sd100, 16'sd100, 16'sd100};
        send_triple(p);                                     // coincident points
        p = '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
              -16'sd32768, -16'sd32768};
        send_triple(p);
        p = '{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767,
              -16'sd32768, -16'sd32768};
        send_triple(p);                                     // largest distances
        p = '{16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768,
              16'sd32767, 16'sd32767};
        send_triple(p);
        p = '{-16'sd32768, 16'sd0, 16'sd32767, 16'sd0, 16'sd32767, 16'sd0};
        send_triple(p);                                     // saturating chord
        p = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0};
        send_triple(p);                                     // one zero distance
        p = '{16'sd0, 16'sd0, 16'sd16, 16'sd0, 16'sd16, 16'sd0};
        send_triple(p);
        p = '{16'sd1, -16'sd1, 16'sd0, 16'sd0, -16'sd1, 16'sd1};
        send_triple(p);                                     // rounding halves
        p = '{16'sd32767, -16'sd32768, 16'sd0, 16'sd0, -16'sd32768, 16'sd32767};
        send_triple(p);
    endtask

    task automatic test_random(int n, int idle, int stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        repeat (n) send_triple(rand_triple());
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // hold the receiver off while the sender keeps offering, then release
    task automatic test_backpressure();
        hold_off <= 1'b1;
        fork
            repeat (80) send_triple(rand_triple());
            begin
                wait (hold_cycles >= 200);
                hold_off <= 1'b0;
            end
        join
    endtask

    initial begin
        errors         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off       = 1'b0;
        quiet_cycles   = 0;
        tension_q15    = scp_pkg::TENSION_RESET;
        i_rst_n        = 1'b0;
        pt_ch.valid    = 1'b0;
        pt_ch.prev_x   = '0;
        pt_ch.prev_y   = '0;
        pt_ch.mid_x    = '0;
        pt_ch.mid_y    = '0;
        pt_ch.next_x   = '0;
        pt_ch.next_y   = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.tension = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        write_tension(16'd0);
        test_directed();
        write_tension(16'd32768);
        test_directed();
        test_random(300, 0, 0);
        write_tension(16'hFFFF);                // tension near 2.0
        test_directed();
        test_random(300, 58, 0);
        write_tension(16'($urandom_range(32768)));
        test_random(300, 0, 58);
        test_backpressure();
        write_tension(16'($urandom));
        test_random(300, 7, 7);
        write_tension(16'd1);
        test_random(200, 0, 0);
        write_tension(16'd16384);
        test_random(300, 58, 58);

        drain();
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
